// File: src/d2q9_pkg.sv
// Shared types, constants and helper functions of the D2Q9 collision unit.
package d2q9_pkg;

   localparam int NUM_DIR = 9;
   localparam int DIST_W = 32;
   localparam int DATA_W = NUM_DIR * DIST_W;
   localparam int DIV_STAGES = 27;
   localparam int DIV_REM_W = 62;
   localparam int OMEGA_W = 26;
   localparam logic [OMEGA_W-1:0] OMEGA_RESET = 26'd16777216;
   localparam logic signed [63:0] Q_ONE = 64'sd16777216;
   localparam logic signed [28:0] VEL_LIM = 29'sd134217728;
   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

   localparam int D_REST = 0;
   localparam int D_EAST = 1;
   localparam int D_NORTH = 2;
   localparam int D_WEST = 3;
   localparam int D_SOUTH = 4;
   localparam int D_NE = 5;
   localparam int D_NW = 6;
   localparam int D_SW = 7;
   localparam int D_SE = 8;

   localparam logic signed [1:0] DIR_EX [NUM_DIR] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0,
                                                      2'sd1, -2'sd1, -2'sd1, 2'sd1};
   localparam logic signed [1:0] DIR_EY [NUM_DIR] = '{2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1,
                                                      2'sd1, 2'sd1, -2'sd1, -2'sd1};
   localparam logic [3:0] DIR_OPP [NUM_DIR] = '{4'd0, 4'd3, 4'd4, 4'd1, 4'd2,
                                               4'd7, 4'd8, 4'd5, 4'd6};
   localparam logic [22:0] DIR_W [NUM_DIR] = '{23'd7456540, 23'd1864135, 23'd1864135,
                                              23'd1864135, 23'd1864135, 23'd466034,
                                              23'd466034, 23'd466034, 23'd466034};

   typedef logic signed [DIST_W-1:0] dist_type;
   typedef dist_type [NUM_DIR-1:0] dist_vec_type;

   typedef struct packed {
      dist_vec_type f;
      logic ob;
      logic bad;
   } side_type;

   typedef struct packed {
      logic signed [35:0] rho;
      logic sx;
      logic sy;
      logic satx;
      logic saty;
   } divc_type;

   function automatic dist_type sat32(input logic signed [63:0] v);
      dist_type r;
      if (v > S32_MAX) r = dist_type'(S32_MAX);
      else if (v < S32_MIN) r = dist_type'(S32_MIN);
      else r = dist_type'(v);
      return r;
   endfunction

   function automatic logic signed [29:0] dir_dot(input logic signed [1:0] e,
                                                  input logic signed [28:0] u);
      logic signed [29:0] r;
      if (e == 2'sd1) r = 30'(u);
      else if (e == -2'sd1) r = -30'(u);
      else r = '0;
      return r;
   endfunction

endpackage

// File: src/d2q9_bgk_collide_bounceback_unit.sv
// Top level of the D2Q9 BGK collision and bounce-back pipeline.
//
//  Port group  Direction  Word
//  req_        in         tdata: nine distributions, rest first; tuser: obstacle flag
//  rsp_        out        tdata: nine new distributions, rest first; tuser: bad density
//  csr_        in         relaxation rate omega, Q.24
//
// One word is accepted every cycle unless the result side stalls.
// The pipeline is the 27-stage velocity divider plus ten arithmetic stages.
// Reset clears all valid bits and sets omega to 1.0.
// A stall on the result side holds the whole pipeline; nothing is lost or repeated.
module d2q9_bgk_collide_bounceback_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [d2q9_pkg::DATA_W-1:0]   req_tdata,   // dist_rest .. dist_southeast
   input  logic                          req_tuser,   // is_obstacle
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [d2q9_pkg::DATA_W-1:0]   rsp_tdata,   // new_rest .. new_southeast
   output logic                          rsp_tuser,   // bad_density
   input  logic                          csr_wen,
   input  logic [d2q9_pkg::OMEGA_W-1:0]  csr_wdata
);

   localparam int ND = d2q9_pkg::NUM_DIR;
   localparam int NDIV = d2q9_pkg::DIV_STAGES;
   localparam int S_P2 = 1;
   localparam int S_D0 = 2;
   localparam int S_DL = S_D0 + NDIV - 1;
   localparam int S_P3 = S_DL + 1;
   localparam int S_P4 = S_P3 + 1;
   localparam int S_P5 = S_P4 + 1;
   localparam int S_P6 = S_P5 + 1;
   localparam int S_P7 = S_P6 + 1;
   localparam int S_P8 = S_P7 + 1;
   localparam int S_P9 = S_P8 + 1;
   localparam int NSTG = S_P9 + 1;

   logic adv;
   logic [d2q9_pkg::OMEGA_W-1:0] omega_ff;
   logic [NSTG-1:0] vld_ff;
   d2q9_pkg::side_type side_ff [NSTG];
   d2q9_pkg::side_type side0_in;
   logic bad_in;

   logic signed [35:0] rho_in, mx_in, my_in;
   logic signed [35:0] rho_ff;
   logic [33:0] ax_ff, ay_ff;
   logic sx_ff, sy_ff;
   d2q9_pkg::divc_type dc_ff [NDIV];
   d2q9_pkg::divc_type dc0_in;
   logic [NDIV-1:0] quot_x, quot_y;

   logic signed [28:0] ux_in, uy_in, ux_ff, uy_ff;
   logic signed [35:0] rho3_ff;
   logic signed [29:0] cu4_ff [ND];
   logic signed [59:0] rwp_ff [ND];
   logic signed [57:0] uxx_ff, uyy_ff;
   logic signed [29:0] cu5_ff [ND];
   logic signed [59:0] cusq_ff [ND];
   logic signed [58:0] usq_ff;
   d2q9_pkg::dist_type rw5_ff [ND];
   d2q9_pkg::dist_type poly_ff [ND];
   d2q9_pkg::dist_type rw6_ff [ND];
   logic signed [63:0] eq_ff [ND];
   logic signed [32:0] diff_ff [ND];
   logic signed [59:0] rel_ff [ND];

   logic rsp_valid_ff;
   d2q9_pkg::dist_vec_type rsp_data_ff, rsp_data_in;
   logic rsp_bad_ff;

   assign adv = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         omega_ff <= d2q9_pkg::OMEGA_RESET;
      end else if (csr_wen) begin
         omega_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_tvalid};
         rsp_valid_ff <= vld_ff[NSTG-1];
      end
   end

   always_comb begin
      side0_in.f = d2q9_pkg::dist_vec_type'(req_tdata);
      side0_in.ob = req_tuser;
      side0_in.bad = 1'b0;
   end

   // Density and momentum of the word in the first stage.
   always_comb begin
      d2q9_pkg::dist_vec_type f;
      f = side_ff[0].f;
      rho_in = '0;
      for (int i = 0; i < ND; i++) begin
         rho_in = rho_in + 36'(f[i]);
      end
      mx_in = 36'(f[d2q9_pkg::D_EAST]) + 36'(f[d2q9_pkg::D_NE]) + 36'(f[d2q9_pkg::D_SE])
            - 36'(f[d2q9_pkg::D_WEST]) - 36'(f[d2q9_pkg::D_NW]) - 36'(f[d2q9_pkg::D_SW]);
      my_in = 36'(f[d2q9_pkg::D_NORTH]) + 36'(f[d2q9_pkg::D_NE]) + 36'(f[d2q9_pkg::D_NW])
            - 36'(f[d2q9_pkg::D_SOUTH]) - 36'(f[d2q9_pkg::D_SW]) - 36'(f[d2q9_pkg::D_SE]);
      bad_in = !side_ff[0].ob && (rho_in <= 36'sd0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side0_in;
         side_ff[S_P2].f <= side_ff[0].f;
         side_ff[S_P2].ob <= side_ff[0].ob;
         side_ff[S_P2].bad <= bad_in;
         for (int k = S_D0; k < NSTG; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         rho_ff <= rho_in;
         sx_ff <= mx_in[35];
         sy_ff <= my_in[35];
         ax_ff <= mx_in[35] ? 34'(-mx_in) : mx_in[33:0];
         ay_ff <= my_in[35] ? 34'(-my_in) : my_in[33:0];
      end
   end

   always_comb begin
      dc0_in.rho = rho_ff;
      dc0_in.sx = sx_ff;
      dc0_in.sy = sy_ff;
      dc0_in.satx = {4'b0000, ax_ff} >= {rho_ff[34:0], 3'b000};
      dc0_in.saty = {4'b0000, ay_ff} >= {rho_ff[34:0], 3'b000};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dc_ff[0] <= dc0_in;
         for (int k = 1; k < NDIV; k++) begin
            dc_ff[k] <= dc_ff[k-1];
         end
      end
   end

   d2q9_div u_div_x (
      .clock (clock),
      .adv   (adv),
      .num   ({ax_ff, 24'b0}),
      .den   (rho_ff[34:0]),
      .quot  (quot_x)
   );

   d2q9_div u_div_y (
      .clock (clock),
      .adv   (adv),
      .num   ({ay_ff, 24'b0}),
      .den   (rho_ff[34:0]),
      .quot  (quot_y)
   );

   always_comb begin
      logic [28:0] mx_mag, my_mag;
      mx_mag = dc_ff[NDIV-1].satx ? 29'(d2q9_pkg::VEL_LIM) : {2'b00, quot_x};
      my_mag = dc_ff[NDIV-1].saty ? 29'(d2q9_pkg::VEL_LIM) : {2'b00, quot_y};
      ux_in = dc_ff[NDIV-1].sx ? -$signed(mx_mag) : $signed(mx_mag);
      uy_in = dc_ff[NDIV-1].sy ? -$signed(my_mag) : $signed(my_mag);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ux_ff <= ux_in;
         uy_ff <= uy_in;
         rho3_ff <= dc_ff[NDIV-1].rho;
         uxx_ff <= ux_ff * ux_ff;
         uyy_ff <= uy_ff * uy_ff;
         usq_ff <= 59'(uxx_ff) + 59'(uyy_ff);
         for (int i = 0; i < ND; i++) begin
            cu4_ff[i] <= d2q9_pkg::dir_dot(d2q9_pkg::DIR_EX[i], ux_ff)
                       + d2q9_pkg::dir_dot(d2q9_pkg::DIR_EY[i], uy_ff);
            rwp_ff[i] <= 60'(rho3_ff) * $signed({37'b0, d2q9_pkg::DIR_W[i]});
            cu5_ff[i] <= cu4_ff[i];
            cusq_ff[i] <= 60'(cu4_ff[i]) * 60'(cu4_ff[i]);
            rw5_ff[i] <= d2q9_pkg::sat32(64'(rwp_ff[i] >>> 24));
            rw6_ff[i] <= rw5_ff[i];
            poly_ff[i] <= d2q9_pkg::sat32(d2q9_pkg::Q_ONE + 64'sd3 * 64'(cu5_ff[i])
                          + ((64'sd9 * 64'(cusq_ff[i]) - 64'sd3 * 64'(usq_ff)) >>> 25));
            eq_ff[i] <= 64'(rw6_ff[i]) * 64'(poly_ff[i]);
            diff_ff[i] <= 33'(d2q9_pkg::sat32(eq_ff[i] >>> 24))
                        - 33'(side_ff[S_P7].f[i]);
            rel_ff[i] <= $signed({34'b0, omega_ff}) * 60'(diff_ff[i]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < ND; i++) begin
         if (side_ff[S_P9].ob) begin
            rsp_data_in[i] = side_ff[S_P9].f[d2q9_pkg::DIR_OPP[i]];
         end else if (side_ff[S_P9].bad) begin
            rsp_data_in[i] = side_ff[S_P9].f[i];
         end else begin
            rsp_data_in[i] = d2q9_pkg::sat32(64'(side_ff[S_P9].f[i])
                                             + 64'(rel_ff[i] >>> 24));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_bad_ff <= side_ff[S_P9].bad;
      end
   end

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow the output stage");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("accepted word did not enter the pipeline");

   a_obstacle_not_bad: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_P9] |-> !(side_ff[S_P9].ob && side_ff[S_P9].bad))
      else $error("obstacle cell flagged with bad density");

   a_velocity_limit: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_P3] |-> (ux_ff <= d2q9_pkg::VEL_LIM && ux_ff >= -d2q9_pkg::VEL_LIM
                        && uy_ff <= d2q9_pkg::VEL_LIM && uy_ff >= -d2q9_pkg::VEL_LIM))
      else $error("velocity outside the saturation limit");

endmodule

// File: src/d2q9_div.sv
// Pipelined restoring divider producing one quotient bit per stage.
module d2q9_div (
   input  logic        clock,
   input  logic        adv,
   input  logic [57:0] num,
   input  logic [34:0] den,
   output logic [d2q9_pkg::DIV_STAGES-1:0] quot
);

   localparam int NB = d2q9_pkg::DIV_STAGES;
   localparam int RW = d2q9_pkg::DIV_REM_W;

   logic [RW-1:0] rem_ff [NB];
   logic [34:0]   den_ff [NB];
   logic [NB-1:0] q_ff   [NB];

   for (genvar s = 0; s < NB; s++) begin : g_stage
      logic [RW-1:0] rsrc;
      logic [RW-1:0] dsh;
      logic [34:0]   dsrc;
      logic [NB-1:0] qsrc;

      if (s == 0) begin : g_first
         assign rsrc = RW'(num);
         assign dsrc = den;
         assign qsrc = '0;
      end else begin : g_next
         assign rsrc = rem_ff[s-1];
         assign dsrc = den_ff[s-1];
         assign qsrc = q_ff[s-1];
      end

      assign dsh = RW'(dsrc) << (NB - 1 - s);

      always_ff @(posedge clock) begin
         if (adv) begin
            den_ff[s] <= dsrc;
            if (rsrc >= dsh) begin
               rem_ff[s] <= rsrc - dsh;
               q_ff[s] <= qsrc | (NB'(1) << (NB - 1 - s));
            end else begin
               rem_ff[s] <= rsrc;
               q_ff[s] <= qsrc;
            end
         end
      end
   end

   assign quot = q_ff[NB-1];

endmodule
